FILE: design/pmsc_pkg.sv
// Shared types and constants for the PID motor speed controller.
// No dependencies; every other design file refers to this package by scoped names.
package pmsc_pkg;

   localparam int unsigned GAIN_W    = 24;
   localparam int unsigned TARGET_W  = 16;
   localparam int unsigned MEAS_W    = 16;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned ERR_W     = 17;
   localparam int unsigned DERR_W    = 18;
   localparam int unsigned SUM_W     = 40;
   localparam int unsigned DUTY_W    = 8;
   localparam int unsigned FRAC_BITS = 16;
   localparam int unsigned CSR_IDX_W = 2;

   // integral product is built from two 24x20 partial products
   localparam int unsigned SUM_SPLIT = 20;
   localparam int unsigned P_W       = GAIN_W + 1 + ERR_W;
   localparam int unsigned D_W       = GAIN_W + 1 + DERR_W;
   localparam int unsigned ILO_W     = GAIN_W + SUM_SPLIT;
   localparam int unsigned IHI_W     = GAIN_W + 1 + SUM_W - SUM_SPLIT;
   localparam int unsigned ITERM_W   = 65;
   localparam int unsigned ACC_W     = 64;
   localparam int unsigned PD_W      = 44;

   localparam logic signed [ITERM_W-1:0] TERM_LIM = 65'sh0_4000_0000_0000_0000;
   localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

   localparam logic [TIME_W-1:0] PERIOD_MS = 32'd50;

   localparam logic [CSR_IDX_W-1:0] REG_TARGET_RPM   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KP_GAIN      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KI_DT_GAIN   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KD_RATE_GAIN = 2'd3;

   localparam logic [GAIN_W-1:0] KP_RESET = 24'd6554;
   localparam logic [GAIN_W-1:0] KI_RESET = 24'd164;
   localparam logic [GAIN_W-1:0] KD_RESET = 24'd13107;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_STOP   = 1'b1;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = 2;
   localparam int unsigned QUEUE_CW    = 3;

   typedef struct packed {
      logic                     is_stop;
      logic                     forward;
      logic signed [ERR_W-1:0]  err;
      logic signed [DERR_W-1:0] err_delta;
      logic signed [SUM_W-1:0]  err_sum;
   } op_type;

   typedef struct packed {
      logic [GAIN_W-1:0] kp;
      logic [GAIN_W-1:0] ki;
      logic [GAIN_W-1:0] kd;
   } gains_type;

endpackage

FILE: design/pmsc_front.sv
// Front end: accepts requests, applies the update period, keeps the loop state
// (integral, previous error, last update time, stopped). Uses pmsc_pkg.
module pmsc_front (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic                                      req_command,
   input  logic signed [pmsc_pkg::MEAS_W-1:0]        req_measured_rpm,
   input  logic [pmsc_pkg::TIME_W-1:0]               req_now_ms,
   input  logic signed [pmsc_pkg::TARGET_W-1:0]      target_rpm,
   input  logic                                      target_wr,
   input  logic                                      q_full,
   output logic                                      q_push,
   output pmsc_pkg::op_type                          q_push_op
);

   logic signed [pmsc_pkg::SUM_W-1:0]    error_sum_ff, error_sum_in;
   logic signed [pmsc_pkg::DERR_W-1:0]   prev_error_ff, prev_error_in;
   logic [pmsc_pkg::TIME_W-1:0]          last_update_ff, last_update_in;
   logic                                 stopped_ff, stopped_in;

   logic                                 accept;
   logic                                 is_stop;
   logic                                 timely;
   logic [pmsc_pkg::TIME_W-1:0]          elapsed;
   logic signed [pmsc_pkg::TARGET_W-1:0] tgt;
   logic signed [pmsc_pkg::ERR_W-1:0]    err;
   logic signed [pmsc_pkg::DERR_W-1:0]   err_delta;
   logic signed [pmsc_pkg::SUM_W:0]      sum_wide;
   logic signed [pmsc_pkg::SUM_W-1:0]    sum_sat;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign is_stop   = (req_command == pmsc_pkg::CMD_STOP);
   assign elapsed   = req_now_ms - last_update_ff;
   assign timely    = (elapsed >= pmsc_pkg::PERIOD_MS);

   always_comb begin
      tgt = stopped_ff ? '0 : target_rpm;
      err = $signed({tgt[pmsc_pkg::TARGET_W-1], tgt})
          - $signed({req_measured_rpm[pmsc_pkg::MEAS_W-1], req_measured_rpm});
      err_delta = $signed({err[pmsc_pkg::ERR_W-1], err}) - prev_error_ff;
      sum_wide  = $signed({error_sum_ff[pmsc_pkg::SUM_W-1], error_sum_ff})
                + $signed({{(pmsc_pkg::SUM_W + 1 - pmsc_pkg::ERR_W){err[pmsc_pkg::ERR_W-1]}},
                           err});
      // saturate when the carry out disagrees with the sign
      if (sum_wide[pmsc_pkg::SUM_W] != sum_wide[pmsc_pkg::SUM_W-1]) begin
         sum_sat = sum_wide[pmsc_pkg::SUM_W]
                 ? {1'b1, {(pmsc_pkg::SUM_W-1){1'b0}}}
                 : {1'b0, {(pmsc_pkg::SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[pmsc_pkg::SUM_W-1:0];
      end
   end

   always_comb begin
      error_sum_in   = error_sum_ff;
      prev_error_in  = prev_error_ff;
      last_update_in = last_update_ff;
      stopped_in     = stopped_ff;
      q_push         = 1'b0;
      q_push_op.is_stop   = is_stop;
      q_push_op.forward   = is_stop ? 1'b1 : !tgt[pmsc_pkg::TARGET_W-1];
      q_push_op.err       = err;
      q_push_op.err_delta = err_delta;
      q_push_op.err_sum   = sum_sat;
      if (accept && is_stop) begin
         error_sum_in  = '0;
         prev_error_in = '0;
         stopped_in    = 1'b1;
         q_push        = 1'b1;
      end else if (accept && (req_command == pmsc_pkg::CMD_UPDATE) && timely) begin
         error_sum_in   = sum_sat;
         prev_error_in  = $signed({err[pmsc_pkg::ERR_W-1], err});
         last_update_in = req_now_ms;
         q_push         = 1'b1;
      end
      if (target_wr) begin
         stopped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff   <= '0;
         prev_error_ff  <= '0;
         last_update_ff <= '0;
         stopped_ff     <= 1'b0;
      end else begin
         error_sum_ff   <= error_sum_in;
         prev_error_ff  <= prev_error_in;
         last_update_ff <= last_update_in;
         stopped_ff     <= stopped_in;
      end
   end

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && is_stop && !target_wr) |=>
         (stopped_ff && error_sum_ff == '0 && prev_error_ff == '0))
      else $error("stop did not clear loop state");

endmodule

FILE: design/pmsc_queue.sv
// Four-entry queue of classified operations between front and back ends.
// Uses pmsc_pkg for the entry type and depth.
module pmsc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pmsc_pkg::op_type push_op,
   input  logic             pop,
   output pmsc_pkg::op_type pop_op,
   output logic             full,
   output logic             empty
);

   pmsc_pkg::op_type                   entry_ff [pmsc_pkg::QUEUE_DEPTH];
   logic [pmsc_pkg::QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [pmsc_pkg::QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [pmsc_pkg::QUEUE_CW-1:0]      count_ff, count_in;

   assign full   = (count_ff == pmsc_pkg::QUEUE_CW'(pmsc_pkg::QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign pop_op = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pmsc_pkg::QUEUE_CW'(pmsc_pkg::QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

FILE: design/pmsc_back.sv
// Back end: three-stage PID datapath (products, integral combine, sum and clamp)
// ending in the result register. Uses pmsc_pkg.
module pmsc_back (
   input  logic                               clock,
   input  logic                               reset,
   input  pmsc_pkg::gains_type                gains,
   input  logic                               q_empty,
   input  pmsc_pkg::op_type                   q_op,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [pmsc_pkg::DUTY_W-1:0]        rsp_pwm_duty,
   output logic                               rsp_forward,
   output logic                               rsp_motor_stop
);

   logic                                  advance;

   // stage 1: partial products
   logic                                  s1_valid_ff, s1_stop_ff, s1_fwd_ff;
   logic signed [pmsc_pkg::P_W-1:0]       s1_p_ff, s1_p_in;
   logic signed [pmsc_pkg::D_W-1:0]       s1_d_ff, s1_d_in;
   logic [pmsc_pkg::ILO_W-1:0]            s1_ilo_ff, s1_ilo_in;
   logic signed [pmsc_pkg::IHI_W-1:0]     s1_ihi_ff, s1_ihi_in;

   // stage 2: integral term and p+d
   logic                                  s2_valid_ff, s2_stop_ff, s2_fwd_ff;
   logic signed [pmsc_pkg::ACC_W-1:0]     s2_iterm_ff, s2_iterm_in;
   logic signed [pmsc_pkg::PD_W-1:0]      s2_pd_ff, s2_pd_in;
   logic signed [pmsc_pkg::ITERM_W-1:0]   i_full;

   // stage 3: result register
   logic                                  rsp_valid_ff;
   logic [pmsc_pkg::DUTY_W-1:0]           rsp_duty_ff, rsp_duty_in;
   logic                                  rsp_fwd_ff, rsp_stop_ff;
   logic signed [pmsc_pkg::ACC_W-1:0]     acc;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign q_pop   = advance && !q_empty;

   always_comb begin
      s1_p_in   = $signed({1'b0, gains.kp}) * q_op.err;
      s1_d_in   = $signed({1'b0, gains.kd}) * q_op.err_delta;
      s1_ilo_in = gains.ki * q_op.err_sum[pmsc_pkg::SUM_SPLIT-1:0];
      s1_ihi_in = $signed({1'b0, gains.ki})
                * $signed(q_op.err_sum[pmsc_pkg::SUM_W-1:pmsc_pkg::SUM_SPLIT]);
   end

   always_comb begin
      i_full = ($signed({{(pmsc_pkg::ITERM_W - pmsc_pkg::IHI_W){s1_ihi_ff[pmsc_pkg::IHI_W-1]}},
                         s1_ihi_ff}) <<< pmsc_pkg::SUM_SPLIT)
             + $signed({{(pmsc_pkg::ITERM_W - pmsc_pkg::ILO_W){1'b0}}, s1_ilo_ff});
      if (i_full > pmsc_pkg::TERM_LIM) begin
         s2_iterm_in = pmsc_pkg::TERM_LIM[pmsc_pkg::ACC_W-1:0];
      end else if (i_full < -pmsc_pkg::TERM_LIM) begin
         s2_iterm_in = pmsc_pkg::ACC_W'(-pmsc_pkg::TERM_LIM);
      end else begin
         s2_iterm_in = i_full[pmsc_pkg::ACC_W-1:0];
      end
      s2_pd_in = $signed({{(pmsc_pkg::PD_W - pmsc_pkg::P_W){s1_p_ff[pmsc_pkg::P_W-1]}}, s1_p_ff})
               + $signed({{(pmsc_pkg::PD_W - pmsc_pkg::D_W){s1_d_ff[pmsc_pkg::D_W-1]}}, s1_d_ff});
   end

   always_comb begin
      acc = s2_iterm_ff
          + $signed({{(pmsc_pkg::ACC_W - pmsc_pkg::PD_W){s2_pd_ff[pmsc_pkg::PD_W-1]}}, s2_pd_ff});
      if (s2_stop_ff || acc[pmsc_pkg::ACC_W-1]) begin
         rsp_duty_in = '0;
      end else if (|acc[pmsc_pkg::ACC_W-2:pmsc_pkg::FRAC_BITS+pmsc_pkg::DUTY_W]) begin
         rsp_duty_in = pmsc_pkg::DUTY_MAX;
      end else begin
         rsp_duty_in = acc[pmsc_pkg::FRAC_BITS+pmsc_pkg::DUTY_W-1:pmsc_pkg::FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_stop_ff  <= q_op.is_stop;
         s1_fwd_ff   <= q_op.forward;
         s1_p_ff     <= s1_p_in;
         s1_d_ff     <= s1_d_in;
         s1_ilo_ff   <= s1_ilo_in;
         s1_ihi_ff   <= s1_ihi_in;
         s2_stop_ff  <= s1_stop_ff;
         s2_fwd_ff   <= s1_fwd_ff;
         s2_iterm_ff <= s2_iterm_in;
         s2_pd_ff    <= s2_pd_in;
         rsp_duty_ff <= rsp_duty_in;
         rsp_fwd_ff  <= s2_fwd_ff;
         rsp_stop_ff <= s2_stop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= !q_empty;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pwm_duty   = rsp_duty_ff;
   assign rsp_forward    = rsp_fwd_ff;
   assign rsp_motor_stop = rsp_stop_ff;

   a_stop_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stop_ff) |-> (rsp_duty_ff == '0 && rsp_fwd_ff))
      else $error("stop result carries drive");

endmodule

FILE: design/pid_motor_speed_controller_core.sv
// Top level of the PID motor speed controller: configuration registers and the
// front end, queue and back end. Depends on pmsc_pkg, pmsc_front, pmsc_queue, pmsc_back.

// One request is taken per clock while req_stall is low. The loop state (integral,
// previous error, last update time, stop flag) is updated in the cycle a request is
// accepted, so requests may follow each other in consecutive cycles. A stop always
// yields a result; a measurement yields one only when at least 50 ms have passed
// since the last used update, otherwise it is dropped. Each result passes through
// the queue and a three-stage multiply, integral-combine and clamp pipeline to the
// output register. A four-entry queue sits between front and back end, so req_stall
// rises only once the queue is full, which takes five to seven results held back by
// rsp_stall depending on gaps in the pipeline. The user must write the registers
// only while the block is idle; the block itself does not enforce this.
module pid_motor_speed_controller_core (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic                                      req_command,
   input  logic signed [pmsc_pkg::MEAS_W-1:0]        req_measured_rpm,
   input  logic [pmsc_pkg::TIME_W-1:0]               req_now_ms,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [pmsc_pkg::DUTY_W-1:0]               rsp_pwm_duty,
   output logic                                      rsp_forward,
   output logic                                      rsp_motor_stop,
   input  logic                                      csr_write_en,
   input  logic [pmsc_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [pmsc_pkg::GAIN_W-1:0]               csr_wdata
);

   logic signed [pmsc_pkg::TARGET_W-1:0] target_ff, target_in;
   pmsc_pkg::gains_type                  gains_ff, gains_in;
   logic                                 target_wr;

   logic                                 q_push, q_pop, q_full, q_empty;
   pmsc_pkg::op_type                     q_push_op, q_pop_op;

   always_comb begin
      target_in = target_ff;
      gains_in  = gains_ff;
      target_wr = 1'b0;
      if (csr_write_en) begin
         unique case (csr_index)
            pmsc_pkg::REG_TARGET_RPM: begin
               target_in = $signed(csr_wdata[pmsc_pkg::TARGET_W-1:0]);
               target_wr = 1'b1;
            end
            pmsc_pkg::REG_KP_GAIN:      gains_in.kp = csr_wdata;
            pmsc_pkg::REG_KI_DT_GAIN:   gains_in.ki = csr_wdata;
            pmsc_pkg::REG_KD_RATE_GAIN: gains_in.kd = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= '0;
         gains_ff.kp <= pmsc_pkg::KP_RESET;
         gains_ff.ki <= pmsc_pkg::KI_RESET;
         gains_ff.kd <= pmsc_pkg::KD_RESET;
      end else begin
         target_ff <= target_in;
         gains_ff  <= gains_in;
      end
   end

   pmsc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_measured_rpm (req_measured_rpm),
      .req_now_ms       (req_now_ms),
      .target_rpm       (target_ff),
      .target_wr        (target_wr),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_push_op        (q_push_op)
   );

   pmsc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (q_push_op),
      .pop     (q_pop),
      .pop_op  (q_pop_op),
      .full    (q_full),
      .empty   (q_empty)
   );

   pmsc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .gains          (gains_ff),
      .q_empty        (q_empty),
      .q_op           (q_pop_op),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pwm_duty   (rsp_pwm_duty),
      .rsp_forward    (rsp_forward),
      .rsp_motor_stop (rsp_motor_stop)
   );

endmodule
